[rtl/core/bmt_pkg.sv]
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types, constants and datapath op codes for the binomial mod p core.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int TABLE_SIZE_DEF = 4096;
    localparam int TOP_W          = 12;
    localparam int MOD_W          = 31;
    localparam int PROD_W         = 2 * MOD_W;
    localparam int DCNT_W         = $clog2(PROD_W + 1);
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef struct packed {
        logic [TOP_W-1:0] top;
        logic [TOP_W-1:0] pick;
    } query_t;

    typedef struct packed {
        logic [MOD_W-1:0] binomial;
        logic             status;
    } result_t;

    localparam int OP_W = 5;

    localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_W-1:0] OP_F_INIT = 5'd1;
    localparam logic [OP_W-1:0] OP_F_DIV  = 5'd2;
    localparam logic [OP_W-1:0] OP_F_MUL  = 5'd3;
    localparam logic [OP_W-1:0] OP_MOD    = 5'd4;
    localparam logic [OP_W-1:0] OP_F_ST   = 5'd5;
    localparam logic [OP_W-1:0] OP_CLR_I  = 5'd6;
    localparam logic [OP_W-1:0] OP_V_ONE  = 5'd7;
    localparam logic [OP_W-1:0] OP_V_DIV  = 5'd8;
    localparam logic [OP_W-1:0] OP_V_RD   = 5'd9;
    localparam logic [OP_W-1:0] OP_V_MUL  = 5'd10;
    localparam logic [OP_W-1:0] OP_V_ST   = 5'd11;
    localparam logic [OP_W-1:0] OP_P_INIT = 5'd12;
    localparam logic [OP_W-1:0] OP_P_RD   = 5'd13;
    localparam logic [OP_W-1:0] OP_P_MUL  = 5'd14;
    localparam logic [OP_W-1:0] OP_P_ST   = 5'd15;
    localparam logic [OP_W-1:0] OP_Q_LOAD = 5'd16;
    localparam logic [OP_W-1:0] OP_Q_RD1  = 5'd17;
    localparam logic [OP_W-1:0] OP_Q_MUL1 = 5'd18;
    localparam logic [OP_W-1:0] OP_Q_RD2  = 5'd19;
    localparam logic [OP_W-1:0] OP_Q_MUL2 = 5'd20;
    localparam logic [OP_W-1:0] OP_Q_FIN  = 5'd21;
    localparam logic [OP_W-1:0] OP_EMIT   = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic i_end;
        logic i_one;
        logic div_busy;
        logic need_mul;
        logic p_zero;
    } sts_t;

endpackage

[rtl/core/bmt_divider.sv]
// ----------------------------------------------------------------------------
// bmt_divider
// Restoring divider, one quotient bit per cycle over the full product width.
// ----------------------------------------------------------------------------
module bmt_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bmt_pkg::PROD_W-1:0]  dividend,
    input  logic [bmt_pkg::MOD_W-1:0]   divisor,
    output logic                        busy,
    output logic [bmt_pkg::MOD_W-1:0]   quotient,
    output logic [bmt_pkg::MOD_W-1:0]   remainder
);
    import bmt_pkg::*;

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [MOD_W-1:0]  dsr_reg;
    logic [MOD_W-1:0]  rem_reg;
    logic [MOD_W-1:0]  quo_reg;
    logic [MOD_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(PROD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PROD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[MOD_W-2:0], ge};
            if (ge)
            begin
                rem_reg <= MOD_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial[MOD_W-1:0];
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/bmt_datapath.sv]
// ----------------------------------------------------------------------------
// bmt_datapath
// Modulus register, factorial tables, multiplier, divider and result registers.
// ----------------------------------------------------------------------------
module bmt_datapath #(
    parameter int TABLE_SIZE = bmt_pkg::TABLE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bmt_pkg::MOD_W-1:0]  cfg_data,
    input  bmt_pkg::query_t            in_data,
    input  bmt_pkg::cmd_t              cmd,
    output bmt_pkg::sts_t              sts,
    output bmt_pkg::result_t           out_data
);
    import bmt_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int IW = AW + 1;

    logic [MOD_W-1:0]  p_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     i_next;
    logic [MOD_W-1:0]  acc_reg;
    logic [MOD_W-1:0]  acc_next;
    logic [MOD_W-1:0]  opb_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [AW-1:0]     n_reg;
    logic [AW-1:0]     k_reg;
    logic              need_mul_reg;
    result_t           pend_reg;
    result_t           res_reg;

    logic [MOD_W-1:0]  fact_mem [TABLE_SIZE];
    logic [MOD_W-1:0]  inv_mem  [TABLE_SIZE];
    logic [MOD_W-1:0]  fact_rd_reg;
    logic [MOD_W-1:0]  inv_rd_reg;

    logic              f_we;
    logic [AW-1:0]     f_wa;
    logic [MOD_W-1:0]  f_wd;
    logic [AW-1:0]     f_ra;
    logic              v_we;
    logic [AW-1:0]     v_wa;
    logic [MOD_W-1:0]  v_wd;
    logic [AW-1:0]     v_ra;

    logic              div_start;
    logic [PROD_W-1:0] div_dvd;
    logic [MOD_W-1:0]  div_dsr;
    logic              div_busy;
    logic [MOD_W-1:0]  div_quo;
    logic [MOD_W-1:0]  div_rem;

    logic              mul_en;
    logic [MOD_W-1:0]  mul_a;
    logic [MOD_W-1:0]  mul_b;

    logic [MOD_W-1:0]  one_p;
    logic [31:0]       top_ext;
    logic [31:0]       pick_ext;
    logic              q_err;
    logic              q_triv;

    bmt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign one_p    = (p_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
    assign top_ext  = 32'(in_data.top);
    assign pick_ext = 32'(in_data.pick);
    assign q_err    = (pick_ext > top_ext) || (top_ext >= 32'(TABLE_SIZE));
    assign q_triv   = (pick_ext == 32'd0) || (pick_ext == top_ext);

    always_comb
    begin
        i_next    = i_reg;
        acc_next  = acc_reg;
        f_we      = 1'b0;
        f_wa      = i_reg[AW-1:0];
        f_wd      = div_rem;
        f_ra      = n_reg;
        v_we      = 1'b0;
        v_wa      = i_reg[AW-1:0];
        v_wd      = div_rem;
        v_ra      = i_reg[AW-1:0];
        div_start = 1'b0;
        div_dvd   = prod_reg;
        div_dsr   = p_reg;
        mul_en    = 1'b0;
        mul_a     = acc_reg;
        mul_b     = inv_rd_reg;
        case (cmd.op)
            OP_F_INIT:
            begin
                f_we     = 1'b1;
                f_wa     = '0;
                f_wd     = one_p;
                acc_next = one_p;
                i_next   = IW'(1);
            end
            OP_F_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = PROD_W'(i_reg);
            end
            OP_F_MUL:
            begin
                mul_en = 1'b1;
                mul_b  = div_rem;
            end
            OP_MOD:
            begin
                div_start = 1'b1;
            end
            OP_F_ST:
            begin
                f_we     = 1'b1;
                acc_next = div_rem;
                i_next   = i_reg + 1'b1;
            end
            OP_CLR_I:
            begin
                i_next = '0;
            end
            OP_V_ONE:
            begin
                v_we   = 1'b1;
                v_wd   = MOD_W'(1);
                i_next = i_reg + 1'b1;
            end
            OP_V_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = PROD_W'(p_reg);
                div_dsr   = MOD_W'(i_reg);
            end
            OP_V_RD:
            begin
                v_ra = div_rem[AW-1:0];
            end
            OP_V_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = inv_rd_reg;
                mul_b  = opb_reg;
            end
            OP_V_ST:
            begin
                v_we   = 1'b1;
                i_next = i_reg + 1'b1;
            end
            OP_P_INIT:
            begin
                acc_next = MOD_W'(1);
                i_next   = IW'(2);
            end
            OP_P_MUL:
            begin
                mul_en = 1'b1;
            end
            OP_P_ST:
            begin
                v_we     = 1'b1;
                acc_next = div_rem;
                i_next   = i_reg + 1'b1;
            end
            OP_Q_RD1:
            begin
                v_ra = k_reg;
            end
            OP_Q_MUL1:
            begin
                mul_en = 1'b1;
                mul_a  = fact_rd_reg;
            end
            OP_Q_RD2:
            begin
                v_ra     = n_reg - k_reg;
                acc_next = div_rem;
            end
            OP_Q_MUL2:
            begin
                mul_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= MODULUS_RESET;
            i_reg        <= '0;
            need_mul_reg <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            if (cfg_we)
            begin
                p_reg <= cfg_data;
            end
            if (cmd.op == OP_Q_LOAD)
            begin
                need_mul_reg <= !q_err && (p_reg != '0) && !q_triv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.op == OP_V_RD)
        begin
            opb_reg <= (div_quo == '0) ? '0 : p_reg - div_quo;
        end
        if (cmd.op == OP_Q_LOAD)
        begin
            n_reg <= top_ext[AW-1:0];
            k_reg <= pick_ext[AW-1:0];
            if (q_err)
            begin
                pend_reg <= '{binomial: '0, status: 1'b1};
            end
            else if (p_reg == '0)
            begin
                pend_reg <= '{binomial: '0, status: 1'b0};
            end
            else
            begin
                pend_reg <= '{binomial: one_p, status: 1'b0};
            end
        end
        else if (cmd.op == OP_Q_FIN)
        begin
            pend_reg <= '{binomial: div_rem, status: 1'b0};
        end
        if (cmd.op == OP_EMIT)
        begin
            res_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fact_mem[f_wa] <= f_wd;
        end
        fact_rd_reg <= fact_mem[f_ra];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            inv_mem[v_wa] <= v_wd;
        end
        inv_rd_reg <= inv_mem[v_ra];
    end

    assign sts.i_end    = (i_reg == IW'(TABLE_SIZE));
    assign sts.i_one    = (i_reg == IW'(1));
    assign sts.div_busy = div_busy;
    assign sts.need_mul = need_mul_reg;
    assign sts.p_zero   = (p_reg == '0);
    assign out_data     = res_reg;

endmodule

[rtl/core/bmt_ctrl.sv]
// ----------------------------------------------------------------------------
// bmt_ctrl
// Sequencer for table rebuild and queries; owns the handshakes.
// ----------------------------------------------------------------------------
module bmt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  bmt_pkg::sts_t  sts,
    output bmt_pkg::cmd_t  cmd
);
    import bmt_pkg::*;

    localparam int SW = 6;

    localparam logic [SW-1:0] S_IDLE   = 6'd0;
    localparam logic [SW-1:0] S_F_INIT = 6'd1;
    localparam logic [SW-1:0] S_F_TOP  = 6'd2;
    localparam logic [SW-1:0] S_F_DW   = 6'd3;
    localparam logic [SW-1:0] S_F_MUL  = 6'd4;
    localparam logic [SW-1:0] S_F_MOD  = 6'd5;
    localparam logic [SW-1:0] S_F_MW   = 6'd6;
    localparam logic [SW-1:0] S_F_ST   = 6'd7;
    localparam logic [SW-1:0] S_V_CLR  = 6'd8;
    localparam logic [SW-1:0] S_V_ONE  = 6'd9;
    localparam logic [SW-1:0] S_V_TOP  = 6'd10;
    localparam logic [SW-1:0] S_V_DW   = 6'd11;
    localparam logic [SW-1:0] S_V_RD   = 6'd12;
    localparam logic [SW-1:0] S_V_MUL  = 6'd13;
    localparam logic [SW-1:0] S_V_MOD  = 6'd14;
    localparam logic [SW-1:0] S_V_MW   = 6'd15;
    localparam logic [SW-1:0] S_V_ST   = 6'd16;
    localparam logic [SW-1:0] S_P_INIT = 6'd17;
    localparam logic [SW-1:0] S_P_TOP  = 6'd18;
    localparam logic [SW-1:0] S_P_MUL  = 6'd19;
    localparam logic [SW-1:0] S_P_MOD  = 6'd20;
    localparam logic [SW-1:0] S_P_MW   = 6'd21;
    localparam logic [SW-1:0] S_P_ST   = 6'd22;
    localparam logic [SW-1:0] S_Q_DEC  = 6'd23;
    localparam logic [SW-1:0] S_Q_MUL1 = 6'd24;
    localparam logic [SW-1:0] S_Q_MOD1 = 6'd25;
    localparam logic [SW-1:0] S_Q_MW1  = 6'd26;
    localparam logic [SW-1:0] S_Q_MUL2 = 6'd27;
    localparam logic [SW-1:0] S_Q_MOD2 = 6'd28;
    localparam logic [SW-1:0] S_Q_MW2  = 6'd29;
    localparam logic [SW-1:0] S_Q_FIN  = 6'd30;
    localparam logic [SW-1:0] S_EMIT   = 6'd31;

    logic [SW-1:0] state_reg;
    logic [SW-1:0] state_next;
    logic          ready_reg;
    logic          ready_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          take;

    assign take = (state_reg == S_IDLE) && ready_reg && in_valid;

    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (!ready_reg)
                begin
                    if (sts.p_zero)
                    begin
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_F_INIT;
                    end
                end
                else if (in_valid)
                begin
                    cmd.op     = OP_Q_LOAD;
                    state_next = S_Q_DEC;
                end
            end
            S_F_INIT:
            begin
                cmd.op     = OP_F_INIT;
                state_next = S_F_TOP;
            end
            S_F_TOP:
            begin
                if (sts.i_end)
                begin
                    state_next = S_V_CLR;
                end
                else
                begin
                    cmd.op     = OP_F_DIV;
                    state_next = S_F_DW;
                end
            end
            S_F_DW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_F_MUL;
                end
            end
            S_F_MUL:
            begin
                cmd.op     = OP_F_MUL;
                state_next = S_F_MOD;
            end
            S_F_MOD:
            begin
                cmd.op     = OP_MOD;
                state_next = S_F_MW;
            end
            S_F_MW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_F_ST;
                end
            end
            S_F_ST:
            begin
                cmd.op     = OP_F_ST;
                state_next = S_F_TOP;
            end
            S_V_CLR:
            begin
                cmd.op     = OP_CLR_I;
                state_next = S_V_ONE;
            end
            S_V_ONE:
            begin
                cmd.op = OP_V_ONE;
                if (sts.i_one)
                begin
                    state_next = S_V_TOP;
                end
            end
            S_V_TOP:
            begin
                if (sts.i_end)
                begin
                    state_next = S_P_INIT;
                end
                else
                begin
                    cmd.op     = OP_V_DIV;
                    state_next = S_V_DW;
                end
            end
            S_V_DW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_V_RD;
                end
            end
            S_V_RD:
            begin
                cmd.op     = OP_V_RD;
                state_next = S_V_MUL;
            end
            S_V_MUL:
            begin
                cmd.op     = OP_V_MUL;
                state_next = S_V_MOD;
            end
            S_V_MOD:
            begin
                cmd.op     = OP_MOD;
                state_next = S_V_MW;
            end
            S_V_MW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_V_ST;
                end
            end
            S_V_ST:
            begin
                cmd.op     = OP_V_ST;
                state_next = S_V_TOP;
            end
            S_P_INIT:
            begin
                cmd.op     = OP_P_INIT;
                state_next = S_P_TOP;
            end
            S_P_TOP:
            begin
                if (sts.i_end)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_P_RD;
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL:
            begin
                cmd.op     = OP_P_MUL;
                state_next = S_P_MOD;
            end
            S_P_MOD:
            begin
                cmd.op     = OP_MOD;
                state_next = S_P_MW;
            end
            S_P_MW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_P_ST;
                end
            end
            S_P_ST:
            begin
                cmd.op     = OP_P_ST;
                state_next = S_P_TOP;
            end
            S_Q_DEC:
            begin
                if (sts.need_mul)
                begin
                    cmd.op     = OP_Q_RD1;
                    state_next = S_Q_MUL1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_Q_MUL1:
            begin
                cmd.op     = OP_Q_MUL1;
                state_next = S_Q_MOD1;
            end
            S_Q_MOD1:
            begin
                cmd.op     = OP_MOD;
                state_next = S_Q_MW1;
            end
            S_Q_MW1:
            begin
                if (!sts.div_busy)
                begin
                    cmd.op     = OP_Q_RD2;
                    state_next = S_Q_MUL2;
                end
            end
            S_Q_MUL2:
            begin
                cmd.op     = OP_Q_MUL2;
                state_next = S_Q_MOD2;
            end
            S_Q_MOD2:
            begin
                cmd.op     = OP_MOD;
                state_next = S_Q_MW2;
            end
            S_Q_MW2:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_FIN:
            begin
                cmd.op     = OP_Q_FIN;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // modulus change restarts the rebuild
        if (cfg_we)
        begin
            ready_next = 1'b0;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = !take;
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/binomial_mod_prime_table_core.sv]
// ----------------------------------------------------------------------------
// binomial_mod_prime_table_core
// n choose k modulo a configured prime, from factorial and inverse tables.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  query_t  {top, pick}
//   out_*        out   out_valid/out_stall result_t {binomial, status}
//   cfg_*        in    cfg_we             31-bit modulus
//
// A query computes two 31x31 products, each reduced by the 62-step
// restoring divider; trivial, error and zero-modulus requests skip them.
// A new request is taken only once the previous result has been issued.
// After reset or a modulus write the tables are rebuilt, with the same
// divider, before the next request is taken, unless the modulus is zero.
// A request is taken while an earlier result is still stalled at the output.
// ----------------------------------------------------------------------------
module binomial_mod_prime_table_core #(
    parameter int TABLE_SIZE = bmt_pkg::TABLE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bmt_pkg::MOD_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bmt_pkg::query_t            in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bmt_pkg::result_t           out_data
);
    import bmt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bmt_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

[tb/tb_binomial_mod_prime_table_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_table_core
// Sends n-choose-k requests under several moduli, from the reset value through
// zero, one, a small prime and the largest 31-bit prime. Each result is checked
// against a local factorial / inverse-factorial table model. Both handshakes
// idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_binomial_mod_prime_table_core;
    import bmt_pkg::*;

    localparam int  TSIZE       = TABLE_SIZE_DEF;
    localparam longint CYCLE_LIMIT = 40000000;

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    logic [MOD_W-1:0] cfg_data;
    logic    in_valid;
    logic    in_stall;
    query_t  in_data;
    logic    out_valid;
    logic    out_stall;
    result_t out_data;

    binomial_mod_prime_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    longint unsigned fact_tbl [TSIZE];
    longint unsigned ifact_tbl [TSIZE];
    longint unsigned prime_p;
    result_t         pending_results [$];
    int              error_count;
    longint          cycle_count;
    bit              quiet;
    bit              hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void rebuild_tables();
        longint unsigned i;
        if (prime_p != 0)
        begin
            fact_tbl[0] = 1 % prime_p;
            for (i = 1; i < TSIZE; i++)
                fact_tbl[i] = (fact_tbl[i-1] * (i % prime_p)) % prime_p;
            ifact_tbl[0] = 1;
            ifact_tbl[1] = 1;
            for (i = 2; i < TSIZE; i++)
                ifact_tbl[i] = (ifact_tbl[prime_p % i]
                                * ((prime_p - prime_p / i) % prime_p)) % prime_p;
            for (i = 2; i < TSIZE; i++)
                ifact_tbl[i] = (ifact_tbl[i-1] * ifact_tbl[i]) % prime_p;
        end
    endfunction

    function automatic result_t choose_mod(query_t q);
        result_t r;
        longint unsigned v;
        r.status = 1'b0;
        if (q.pick > q.top)
        begin
            r.binomial = '0;
            r.status   = 1'b1;
            return r;
        end
        if (prime_p == 0)
            v = 0;
        else if (q.pick == 0 || q.pick == q.top)
            v = 1 % prime_p;
        else
        begin
            v = (fact_tbl[q.top] * ifact_tbl[q.pick]) % prime_p;
            v = (v * ifact_tbl[q.top - q.pick]) % prime_p;
        end
        r.binomial = v[MOD_W-1:0];
        return r;
    endfunction

    // request driver
    task automatic send_query(logic [TOP_W-1:0] n, logic [TOP_W-1:0] k);
        int gap;
        query_t q;
        q.top  = n;
        q.pick = k;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= q;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.push_back(choose_mod(q));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        prime_p = v;
        rebuild_tables();
    endtask

    task automatic test_directed();
        send_query(0, 0);
        send_query(4095, 0);
        send_query(4095, 4095);
        send_query(4095, 1);
        send_query(4095, 4094);
        send_query(4095, 2048);
        send_query(1, 0);
        send_query(1, 1);
        send_query(0, 1);
        send_query(0, 4095);
        send_query(4094, 4095);
        send_query(10, 3);
        send_query(2730, 1365);
        send_query(1365, 2730);
        send_query(4095, 2047);
    endtask

    task automatic test_random(int count);
        logic [TOP_W-1:0] n;
        logic [TOP_W-1:0] k;
        int sel;
        repeat (count)
        begin
            n   = $urandom_range(0, 4095);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                k = 0;
            else if (sel == 1)
                k = n;
            else if (sel == 2)
                k = $urandom_range(0, 4095);
            else
                k = $urandom_range(0, n);
            send_query(n, k);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(40);
        hold_req = 1'b0;
    endtask

    task automatic test_small_moduli();
        write_modulus(31'd0);
        test_directed();
        test_random(30);
        write_modulus(31'd1);
        test_random(30);
        write_modulus(31'd4099);
        test_random(60);
    endtask

    // result stall
    initial
    begin
        int run;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold = 0;
                while (hold < 600)
                begin
                    @(negedge clk);
                    hold++;
                end
                out_stall <= 1'b0;
                wait (!hold_req);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                run = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (run) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result binomial=%0d status=%0d",
                         $time, out_data.binomial, out_data.status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_data.binomial !== exp_r.binomial)
                begin
                    $display("%0t binomial mismatch: expected %0d actual %0d",
                             $time, exp_r.binomial, out_data.binomial);
                    error_count++;
                end
                if (out_data.status !== exp_r.status)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_r.status, out_data.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int settle;
        error_count = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        prime_p     = MODULUS_RESET;
        rebuild_tables();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(80);
        test_backpressure();
        test_small_moduli();
        write_modulus(31'h7FFFFFFF);
        test_directed();
        test_random(80);
        quiet = 1'b1;
        test_random(60);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        settle = 0;
        while (settle < 200)
        begin
            @(posedge clk);
            settle++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[sim.f]
rtl/core/bmt_pkg.sv
rtl/core/bmt_divider.sv
rtl/core/bmt_datapath.sv
rtl/core/bmt_ctrl.sv
rtl/core/binomial_mod_prime_table_core.sv
tb/tb_binomial_mod_prime_table_core.sv
